FILE: rtl/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types and constants of the palette cost search: field widths,
// configuration bundle, pipeline tag and item function codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    // field widths fixed by the item and register formats
    localparam int IDX_W   = 8;   // palette index on the ports
    localparam int COUNT_W = 9;   // scan counter, holds 256
    localparam int COEF_W  = 16;  // Q2.14 colour and weight
    localparam int BIAS_W  = 24;  // Q10.14 bookkeeping value
    localparam int TERM_W  = 41;  // one channel term, Q28
    localparam int COST_W  = 48;  // summed cost, Q28
    localparam int CH_NUM  = 4;   // channel fields on the ports

    // item function codes
    localparam logic FUNC_CLASSIFY = 1'b0;
    localparam logic FUNC_LOAD     = 1'b1;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [BIAS_W-1:0] t_bias;
    typedef logic signed [COST_W-1:0] t_cost;

    // configuration register contents
    typedef struct packed {
        logic [COUNT_W-1:0]           colors;
        logic [2:0]                   channels;
        logic [CH_NUM-1:0][COEF_W-1:0] weight;
    } t_cfg;

    // bookkeeping that travels with each palette read
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

`default_nettype wire

FILE: rtl/pca_regs.sv
// ----------------------------------------------------------------------------
// pca_regs
// Configuration register bank behind an APB-style port: colour count,
// channel count and four centre weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pca_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output pca_pkg::t_cfg      o_cfg
);
    import pca_pkg::*;

    typedef enum logic [2:0] {
        REG_COLORS   = 3'd0,
        REG_CHANNELS = 3'd1,
        REG_WEIGHT_0 = 3'd2,
        REG_WEIGHT_1 = 3'd3,
        REG_WEIGHT_2 = 3'd4,
        REG_WEIGHT_3 = 3'd5
    } t_reg_idx;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.colors   <= COUNT_W'(16);
            r_cfg.channels <= 3'd3;
            r_cfg.weight   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_COLORS:   r_cfg.colors    <= pwdata[COUNT_W-1:0];
                REG_CHANNELS: r_cfg.channels  <= pwdata[2:0];
                REG_WEIGHT_0: r_cfg.weight[0] <= pwdata[COEF_W-1:0];
                REG_WEIGHT_1: r_cfg.weight[1] <= pwdata[COEF_W-1:0];
                REG_WEIGHT_2: r_cfg.weight[2] <= pwdata[COEF_W-1:0];
                REG_WEIGHT_3: r_cfg.weight[3] <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (w_idx)
            REG_COLORS:   prdata = 32'(r_cfg.colors);
            REG_CHANNELS: prdata = 32'(r_cfg.channels);
            REG_WEIGHT_0: prdata = 32'(r_cfg.weight[0]);
            REG_WEIGHT_1: prdata = 32'(r_cfg.weight[1]);
            REG_WEIGHT_2: prdata = 32'(r_cfg.weight[2]);
            REG_WEIGHT_3: prdata = 32'(r_cfg.weight[3]);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pca_palette_ram.sv
// ----------------------------------------------------------------------------
// pca_palette_ram
// Single-write, single-read synchronous memory holding the palette, read
// data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pca_palette_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pca_cost.sv
// ----------------------------------------------------------------------------
// pca_cost
// Three-stage cost pipeline: per channel lane b*y, then y*(p + (b*y>>14)),
// then the sum over the lanes. One palette entry enters per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pca_cost #(
    parameter int NCH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [NCH*16-1:0]        i_rdata,
    input  wire pca_pkg::t_tag            i_tag,
    input  wire pca_pkg::t_cfg            i_cfg,
    input  wire logic [2:0]               i_nch,
    input  wire pca_pkg::t_bias           i_bias [NCH],
    output pca_pkg::t_cost                o_cost,
    output pca_pkg::t_tag                 o_tag
);
    import pca_pkg::*;

    t_coef                    w_y     [NCH];
    logic signed [31:0]       r_a_prod[NCH];
    t_coef                    r_a_y   [NCH];
    t_tag                     r_a_tag;
    logic signed [BIAS_W:0]   w_b_sum [NCH];
    logic signed [TERM_W-1:0] r_b_term[NCH];
    t_tag                     r_b_tag;
    t_cost                    w_c_sum;
    t_cost                    r_c_cost;
    t_tag                     r_c_tag;

    // lane select: channels beyond the active count contribute nothing
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (3'(c) < i_nch) begin
                w_y[c] = $signed(i_rdata[c*COEF_W +: COEF_W]);
            end else begin
                w_y[c] = '0;
            end
        end
    end

    // p plus the product brought back to Q14 (floor shift)
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_b_sum[c] = $signed({r_a_prod[c][31], r_a_prod[c][31], r_a_prod[c][31],
                                  r_a_prod[c][31], r_a_prod[c][31], r_a_prod[c][31],
                                  r_a_prod[c][31], r_a_prod[c][31:14]})
                       + $signed({i_bias[c][BIAS_W-1], i_bias[c]});
        end
    end

    // lane sum
    always_comb begin
        w_c_sum = '0;
        for (int c = 0; c < NCH; c++) begin
            w_c_sum = w_c_sum
                    + $signed({{(COST_W-TERM_W){r_b_term[c][TERM_W-1]}}, r_b_term[c]});
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            r_a_prod[c] <= $signed(i_cfg.weight[c]) * w_y[c];
            r_a_y[c]    <= w_y[c];
            r_b_term[c] <= w_b_sum[c] * r_a_y[c];
        end
        r_c_cost <= w_c_sum;
    end

    // tag stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
        end
    end

    assign o_cost = r_c_cost;
    assign o_tag  = r_c_tag;

endmodule

`default_nettype wire

FILE: rtl/palette_cost_argmin.sv
// ----------------------------------------------------------------------------
// palette_cost_argmin
// Palette search for one pixel: palette memory, cost pipeline, argmin and
// item sequencer.
// ----------------------------------------------------------------------------
// A load word (func 1) writes one palette entry and returns its index in the
// cycle after acceptance. A classify word (func 0) scans palette entries
// 0 to colors_in_use-1 through the single read port of the palette memory,
// one entry per cycle; the result then passes the memory read register,
// three cost pipeline stages, the argmin update and the output register.
// One word is worked on at a time; a new word is taken once the result of
// the previous one has moved to the output register. Palette contents are
// undefined until loaded; there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module palette_cost_argmin #(
    parameter int MAX_COLORS   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_func,
    input  wire logic [7:0]           i_entry,
    input  wire logic [7:0]           i_current_index,
    input  wire logic signed [23:0]   i_bias_0,
    input  wire logic signed [23:0]   i_bias_1,
    input  wire logic signed [23:0]   i_bias_2,
    input  wire logic signed [23:0]   i_bias_3,
    input  wire logic signed [15:0]   i_color_0,
    input  wire logic signed [15:0]   i_color_1,
    input  wire logic signed [15:0]   i_color_2,
    input  wire logic signed [15:0]   i_color_3,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [7:0]           o_best_index,
    output logic                      o_index_changed,
    output logic signed [47:0]        o_best_cost
);
    import pca_pkg::*;

    localparam int AW       = $clog2(MAX_COLORS);
    localparam int NCOL_LIM = (MAX_COLORS < 256) ? MAX_COLORS : 256;
    localparam int DW       = MAX_CHANNELS * COEF_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state             r_state;
    t_cfg               w_cfg;
    logic [COUNT_W-1:0] w_ncol;
    logic [2:0]         w_nch;
    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_last;
    logic [COUNT_W-1:0] r_scan;
    t_tag               r_rd_tag;
    logic [DW-1:0]      w_wdata;
    logic [DW-1:0]      w_rdata;
    logic               w_we;
    t_bias              w_bias_in[CH_NUM];
    t_coef              w_color  [CH_NUM];
    t_bias              r_bias   [MAX_CHANNELS];
    logic [IDX_W-1:0]   r_current;
    t_cost              w_cost;
    t_tag               w_tag;
    logic               w_take;
    logic [IDX_W-1:0]   r_best_idx;
    t_cost              r_best_cost;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_index;
    logic               r_out_changed;
    t_cost              r_out_cost;

    // configuration registers
    pca_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // effective colour and channel counts
    always_comb begin
        if (w_cfg.colors > COUNT_W'(NCOL_LIM)) begin
            w_ncol = COUNT_W'(NCOL_LIM);
        end else if (w_cfg.colors == '0) begin
            w_ncol = COUNT_W'(1);
        end else begin
            w_ncol = w_cfg.colors;
        end
        if (w_cfg.channels > 3'(MAX_CHANNELS)) begin
            w_nch = 3'(MAX_CHANNELS);
        end else begin
            w_nch = w_cfg.channels;
        end
    end

    // channel fields as arrays
    assign w_bias_in[0] = i_bias_0;
    assign w_bias_in[1] = i_bias_1;
    assign w_bias_in[2] = i_bias_2;
    assign w_bias_in[3] = i_bias_3;
    assign w_color[0]   = i_color_0;
    assign w_color[1]   = i_color_1;
    assign w_color[2]   = i_color_2;
    assign w_color[3]   = i_color_3;

    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            w_wdata[c*COEF_W +: COEF_W] = w_color[c];
        end
    end

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_we       = w_accept && (i_func == FUNC_LOAD)
                        && (32'(i_entry) < MAX_COLORS);
    assign w_last     = (r_scan == w_ncol - COUNT_W'(1));
    // output register takes a new word this cycle
    assign w_out_load = (w_accept && (i_func == FUNC_LOAD))
                        || ((r_state == ST_DONE) && w_out_free);

    // palette memory
    pca_palette_ram #(
        .DEPTH (MAX_COLORS),
        .WIDTH (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry)),
        .i_wdata (w_wdata),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (AW'(r_scan)),
        .o_rdata (w_rdata)
    );

    // cost pipeline
    pca_cost #(
        .NCH (MAX_CHANNELS)
    ) u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (w_rdata),
        .i_tag   (r_rd_tag),
        .i_cfg   (w_cfg),
        .i_nch   (w_nch),
        .i_bias  (r_bias),
        .o_cost  (w_cost),
        .o_tag   (w_tag)
    );

    // first entry or strictly smaller cost wins
    assign w_take = w_tag.valid && ((w_tag.idx == '0) || (w_cost < r_best_cost));

    // pixel word payload
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_func == FUNC_CLASSIFY)) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_bias[c] <= w_bias_in[c];
            end
            r_current <= i_current_index;
        end
    end

    // sequencer, argmin and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_rd_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            r_rd_tag.valid <= (r_state == ST_SCAN);
            r_rd_tag.last  <= w_last;
            r_rd_tag.idx   <= r_scan[IDX_W-1:0];
            if (w_take) begin
                r_best_idx  <= w_tag.idx;
                r_best_cost <= w_cost;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_func == FUNC_LOAD) begin
                            r_out_valid   <= 1'b1;
                            r_out_index   <= i_entry;
                            r_out_changed <= 1'b0;
                            r_out_cost    <= '0;
                        end else begin
                            r_scan  <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_scan <= r_scan + COUNT_W'(1);
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_tag.valid && w_tag.last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_index   <= r_best_idx;
                        r_out_changed <= (r_best_idx != r_current);
                        r_out_cost    <= r_best_cost;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_best_index    = r_out_index;
    assign o_index_changed = r_out_changed;
    assign o_best_cost     = r_out_cost;

    // scan never runs past the active colour count
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_scan < w_ncol))
        else $error("scan counter beyond colour count");

    // costed entries only arrive while a pixel is in flight
    a_tag_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag.valid |-> ((r_state == ST_SCAN) || (r_state == ST_DRAIN)))
        else $error("costed entry outside a scan");

    // last costed entry closes the search
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tag.valid && w_tag.last) |=> (r_state == ST_DONE))
        else $error("search not closed after last entry");

    // finished search lands in the output register
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=>
        (r_out_valid && (r_out_index == $past(r_best_idx))
         && (r_out_cost == $past(r_best_cost))))
        else $error("search result not delivered");

endmodule

`default_nettype wire
